// File: rtl/core/udt_pkg.sv
package udt_pkg;

    // pipeline depth, stage 0 is the offset add, the last stage is the output register
    localparam int STAGES = 15;
    localparam int OCC_W  = $clog2(STAGES + 1);

    typedef logic [STAGES-1:0] stage_en_t;

    // local seconds are biased by 86400 * (719468 + 88 * 146097) so the whole
    // day split runs on non-negative values; 88 eras shift the year by a
    // multiple of 128, which leaves the 7-bit year field untouched
    localparam logic [41:0] DAY_BIAS_SECS = 42'd1172966745600;

    // seconds per day is 128 * 675
    localparam int DAY_DIV      = 675;
    localparam int RECIP_DAY_HI = 388;      // floor(2^18 / 675)
    localparam int RECIP_DAY_LO = 198841;   // floor(2^27 / 675)

    localparam int ERA_DAYS   = 146097;
    localparam int RECIP_ERA  = 459;        // floor(2^26 / 146097)
    localparam int QUAD_DAYS  = 1460;
    localparam int RECIP_QUAD = 179;        // floor(2^18 / 1460)
    localparam int CENT_DAYS  = 36524;
    localparam int ERA_LAST   = 146096;
    localparam int YEAR_DAYS  = 365;
    localparam int RECIP_YEAR = 718;        // floor(2^18 / 365)

    localparam int SIXTY         = 60;
    localparam int RECIP_MIN_SOD = 2184;    // floor(2^17 / 60)
    localparam int RECIP_MIN_HR  = 34;      // floor(2^11 / 60)

    // (year - 1980) mod 128, with 1980 mod 128 = 60
    localparam logic [6:0] YEAR_ADJ = 7'd68;

    localparam logic [31:0] DOS_LOW  = 32'h0021_0000;
    localparam logic [31:0] DOS_HIGH = 32'hff9f_bf7d;

    // first day of each month counted from march 1st
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/core/udt_if.sv
interface udt_in_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] unix_seconds;

    modport source (output valid, output unix_seconds, input ready);
    modport sink (input valid, input unix_seconds, output ready);
endinterface

interface udt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] dos_word;

    modport source (output valid, output dos_word, input ready);
    modport sink (input valid, input dos_word, output ready);
endinterface

interface udt_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] utc_offset_seconds;

    modport source (output valid, output utc_offset_seconds, input ready);
    modport sink (input valid, input utc_offset_seconds, output ready);
endinterface

// File: rtl/core/udt_day_split.sv
module udt_day_split (
    input  logic               clk,
    input  udt_pkg::stage_en_t en,
    input  logic [41:0]        secs,
    output logic [25:0]        days,
    output logic [16:0]        sod
);
    import udt_pkg::*;

    // stage 1
    logic [26:0] s1_prod;
    logic [8:0]  s1_qest_next;
    logic [8:0]  s1_qest_reg;
    logic [17:0] s1_hi_reg;
    logic [23:0] s1_lo_reg;

    // stage 2
    logic [18:0] s2_rem;
    logic [8:0]  s2_qh_next;
    logic [9:0]  s2_rh_next;
    logic [8:0]  s2_qh_reg;
    logic [9:0]  s2_rh_reg;
    logic [23:0] s2_lo_reg;

    // stage 3
    logic [26:0] s3_x_next;
    logic [44:0] s3_prod;
    logic [16:0] s3_qest_next;
    logic [26:0] s3_x_reg;
    logic [16:0] s3_qest_reg;
    logic [8:0]  s3_qh_reg;
    logic [6:0]  s3_lo_reg;

    // stage 4
    logic [26:0] s4_rem;
    logic [16:0] s4_q_next;
    logic [9:0]  s4_r_next;
    logic [25:0] days_reg;
    logic [16:0] sod_reg;

    // seconds / 128 split into a high part and a low part, divided by 675 as a long division
    always_comb
    begin
        s1_prod      = 27'(secs[41:24]) * 27'(RECIP_DAY_HI);
        s1_qest_next = s1_prod[26:18];
    end

    always_comb
    begin
        s2_rem = 19'(s1_hi_reg) - 19'(s1_qest_reg) * 19'(DAY_DIV);
        if (s2_rem >= 19'(DAY_DIV))
        begin
            s2_qh_next = s1_qest_reg + 9'd1;
            s2_rh_next = 10'(s2_rem - 19'(DAY_DIV));
        end
        else
        begin
            s2_qh_next = s1_qest_reg;
            s2_rh_next = 10'(s2_rem);
        end
    end

    always_comb
    begin
        s3_x_next    = {s2_rh_reg[9:0], s2_lo_reg[23:7]};
        s3_prod      = 45'(s3_x_next) * 45'(RECIP_DAY_LO);
        s3_qest_next = s3_prod[43:27];
    end

    always_comb
    begin
        s4_rem = s3_x_reg - 27'(s3_qest_reg) * 27'(DAY_DIV);
        if (s4_rem >= 27'(DAY_DIV))
        begin
            s4_q_next = s3_qest_reg + 17'd1;
            s4_r_next = 10'(s4_rem - 27'(DAY_DIV));
        end
        else
        begin
            s4_q_next = s3_qest_reg;
            s4_r_next = 10'(s4_rem);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_qest_reg <= s1_qest_next;
            s1_hi_reg   <= secs[41:24];
            s1_lo_reg   <= secs[23:0];
        end
        if (en[2])
        begin
            s2_qh_reg <= s2_qh_next;
            s2_rh_reg <= s2_rh_next;
            s2_lo_reg <= s1_lo_reg;
        end
        if (en[3])
        begin
            s3_x_reg    <= s3_x_next;
            s3_qest_reg <= s3_qest_next;
            s3_qh_reg   <= s2_qh_reg;
            s3_lo_reg   <= s2_lo_reg[6:0];
        end
        if (en[4])
        begin
            days_reg <= {s3_qh_reg, s4_q_next};
            sod_reg  <= {s4_r_next, s3_lo_reg};
        end
    end

    assign days = days_reg;
    assign sod  = sod_reg;

endmodule

// File: rtl/core/udt_calendar.sv
module udt_calendar (
    input  logic               clk,
    input  udt_pkg::stage_en_t en,
    input  logic [25:0]        days,
    input  logic [16:0]        sod,
    output logic [6:0]         year7,
    output logic [3:0]         month,
    output logic [4:0]         day,
    output logic [15:0]        tod
);
    import udt_pkg::*;

    // stage 5
    logic [34:0] s5_era_prod;
    logic [28:0] s5_min_prod;
    logic [8:0]  s5_era_reg;
    logic [10:0] s5_min_reg;
    logic [25:0] s5_days_reg;
    logic [16:0] s5_sod_reg;

    // stage 6
    logic [25:0] s6_rem;
    logic [16:0] s6_srem;
    logic [8:0]  s6_era_next;
    logic [17:0] s6_doe_next;
    logic [10:0] s6_min_next;
    logic [5:0]  s6_sec_next;
    logic [2:0]  s6_era_reg;
    logic [17:0] s6_doe_reg;
    logic [10:0] s6_min_reg;
    logic [5:0]  s6_sec_reg;

    // stage 7
    logic [25:0] s7_quad_prod;
    logic [16:0] s7_hr_prod;
    logic [2:0]  s7_cent_next;
    logic [7:0]  s7_quad_reg;
    logic [2:0]  s7_cent_reg;
    logic        s7_last_reg;
    logic [5:0]  s7_hr_reg;
    logic [2:0]  s7_era_reg;
    logic [17:0] s7_doe_reg;
    logic [10:0] s7_min_reg;
    logic [5:0]  s7_sec_reg;

    // stage 8
    logic [17:0] s8_qrem;
    logic [7:0]  s8_quad;
    logic [10:0] s8_mrem;
    logic [4:0]  s8_hour;
    logic [5:0]  s8_minute;
    logic [17:0] s8_n_next;
    logic [17:0] s8_n_reg;
    logic [2:0]  s8_era_reg;
    logic [17:0] s8_doe_reg;

    // stage 9
    logic [27:0] s9_prod;
    logic [8:0]  s9_yest_reg;
    logic [17:0] s9_n_reg;
    logic [2:0]  s9_era_reg;
    logic [17:0] s9_doe_reg;

    // stage 10
    logic [17:0] s10_rem;
    logic [8:0]  s10_yoe_next;
    logic [8:0]  s10_yoe_reg;
    logic [2:0]  s10_era_reg;
    logic [17:0] s10_doe_reg;

    // stage 11
    logic [1:0]  s11_cent;
    logic [17:0] s11_doy_wide;
    logic [8:0]  s11_doy_reg;
    logic [8:0]  s11_yoe_reg;
    logic [2:0]  s11_era_reg;

    // stage 12
    logic [3:0]  s12_mp_next;
    logic [3:0]  s12_mp_reg;
    logic [8:0]  s12_doy_reg;
    logic [8:0]  s12_yoe_reg;
    logic [2:0]  s12_era_reg;

    // stage 13
    logic        s13_late;
    logic [8:0]  s13_dom;
    logic [6:0]  year_next;
    logic [3:0]  month_next;
    logic [4:0]  day_next;
    logic [6:0]  year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;

    // packed hour, minute and second / 2, carried from stage 8 onward
    logic [15:0] s8_tod_next;
    logic [15:0] tod_reg [13:8];

    // stage 5: estimated era and estimated minute of day
    always_comb
    begin
        s5_era_prod = 35'(days) * 35'(RECIP_ERA);
        s5_min_prod = 29'(sod) * 29'(RECIP_MIN_SOD);
    end

    // stage 6: correct both estimates
    always_comb
    begin
        s6_rem = s5_days_reg - 26'(s5_era_reg) * 26'(ERA_DAYS);
        if (s6_rem >= 26'(ERA_DAYS))
        begin
            s6_era_next = s5_era_reg + 9'd1;
            s6_doe_next = 18'(s6_rem - 26'(ERA_DAYS));
        end
        else
        begin
            s6_era_next = s5_era_reg;
            s6_doe_next = 18'(s6_rem);
        end
        s6_srem = s5_sod_reg - 17'(s5_min_reg) * 17'(SIXTY);
        if (s6_srem >= 17'(SIXTY))
        begin
            s6_min_next = s5_min_reg + 11'd1;
            s6_sec_next = 6'(s6_srem - 17'(SIXTY));
        end
        else
        begin
            s6_min_next = s5_min_reg;
            s6_sec_next = 6'(s6_srem);
        end
    end

    // stage 7: leap corrections of the day of era and the hour estimate
    always_comb
    begin
        s7_quad_prod = 26'(s6_doe_reg) * 26'(RECIP_QUAD);
        s7_cent_next = 3'(s6_doe_reg >= 18'(CENT_DAYS))
                     + 3'(s6_doe_reg >= 18'(2 * CENT_DAYS))
                     + 3'(s6_doe_reg >= 18'(3 * CENT_DAYS))
                     + 3'(s6_doe_reg >= 18'(ERA_LAST));
        s7_hr_prod   = 17'(s6_min_reg) * 17'(RECIP_MIN_HR);
    end

    // stage 8
    always_comb
    begin
        s8_qrem = s7_doe_reg - 18'(s7_quad_reg) * 18'(QUAD_DAYS);
        s8_quad = s7_quad_reg + 8'(s8_qrem >= 18'(QUAD_DAYS));
        s8_n_next = s7_doe_reg - 18'(s8_quad) + 18'(s7_cent_reg) - 18'(s7_last_reg);

        s8_mrem = s7_min_reg - 11'(s7_hr_reg) * 11'(SIXTY);
        if (s8_mrem >= 11'(SIXTY))
        begin
            s8_hour   = 5'(s7_hr_reg + 6'd1);
            s8_minute = 6'(s8_mrem - 11'(SIXTY));
        end
        else
        begin
            s8_hour   = 5'(s7_hr_reg);
            s8_minute = 6'(s8_mrem);
        end
        s8_tod_next = {s8_hour, s8_minute, s7_sec_reg[5:1]};
    end

    // stage 9 and 10: year of era
    always_comb
    begin
        s9_prod = 28'(s8_n_reg) * 28'(RECIP_YEAR);
    end

    always_comb
    begin
        s10_rem      = s9_n_reg - 18'(s9_yest_reg) * 18'(YEAR_DAYS);
        s10_yoe_next = s9_yest_reg + 9'(s10_rem >= 18'(YEAR_DAYS));
    end

    // stage 11: day of the year starting in march
    always_comb
    begin
        s11_cent = 2'(s10_yoe_reg >= 9'd100) + 2'(s10_yoe_reg >= 9'd200)
                 + 2'(s10_yoe_reg >= 9'd300);
        s11_doy_wide = s10_doe_reg
                     - (18'(s10_yoe_reg) * 18'(YEAR_DAYS) + 18'(s10_yoe_reg >> 2)
                        - 18'(s11_cent));
    end

    // stage 12: month index from march
    always_comb
    begin
        s12_mp_next = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            s12_mp_next = s12_mp_next + 4'(s11_doy_reg >= month_start(4'(k)));
        end
    end

    // stage 13: calendar fields
    always_comb
    begin
        s13_late   = (s12_mp_reg >= 4'd10);
        s13_dom    = s12_doy_reg - month_start(s12_mp_reg) + 9'd1;
        day_next   = s13_dom[4:0];
        month_next = s13_late ? (s12_mp_reg - 4'd9) : (s12_mp_reg + 4'd3);
        // january and february belong to the next civil year
        year_next  = s12_yoe_reg[6:0] + {s12_era_reg, 4'b0000} + 7'(s13_late) + YEAR_ADJ;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_era_reg  <= s5_era_prod[34:26];
            s5_min_reg  <= s5_min_prod[27:17];
            s5_days_reg <= days;
            s5_sod_reg  <= sod;
        end
        if (en[6])
        begin
            s6_era_reg <= s6_era_next[2:0];
            s6_doe_reg <= s6_doe_next;
            s6_min_reg <= s6_min_next;
            s6_sec_reg <= s6_sec_next;
        end
        if (en[7])
        begin
            s7_quad_reg <= s7_quad_prod[25:18];
            s7_cent_reg <= s7_cent_next;
            s7_last_reg <= (s6_doe_reg == 18'(ERA_LAST));
            s7_hr_reg   <= s7_hr_prod[16:11];
            s7_era_reg  <= s6_era_reg;
            s7_doe_reg  <= s6_doe_reg;
            s7_min_reg  <= s6_min_reg;
            s7_sec_reg  <= s6_sec_reg;
        end
        if (en[8])
        begin
            s8_n_reg    <= s8_n_next;
            s8_era_reg  <= s7_era_reg;
            s8_doe_reg  <= s7_doe_reg;
            tod_reg[8]  <= s8_tod_next;
        end
        if (en[9])
        begin
            s9_yest_reg <= s9_prod[26:18];
            s9_n_reg    <= s8_n_reg;
            s9_era_reg  <= s8_era_reg;
            s9_doe_reg  <= s8_doe_reg;
        end
        if (en[10])
        begin
            s10_yoe_reg <= s10_yoe_next;
            s10_era_reg <= s9_era_reg;
            s10_doe_reg <= s9_doe_reg;
        end
        if (en[11])
        begin
            s11_doy_reg <= s11_doy_wide[8:0];
            s11_yoe_reg <= s10_yoe_reg;
            s11_era_reg <= s10_era_reg;
        end
        if (en[12])
        begin
            s12_mp_reg  <= s12_mp_next;
            s12_doy_reg <= s11_doy_reg;
            s12_yoe_reg <= s11_yoe_reg;
            s12_era_reg <= s11_era_reg;
        end
        if (en[13])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
        for (int k = 9; k <= 13; k++)
        begin
            if (en[k])
            begin
                tod_reg[k] <= tod_reg[k-1];
            end
        end
    end

    assign year7 = year_reg;
    assign month = month_reg;
    assign day   = day_reg;
    assign tod   = tod_reg[13];

endmodule

// File: rtl/core/unix_seconds_to_dos_datetime_unit.sv
// channel   dir  handshake      payload
// cfg       in   valid / ready  utc_offset_seconds [16:0] signed
// stamp     in   valid / ready  unix_seconds [39:0] signed
// result    out  valid / ready  dos_word [31:0]
//
// one item per cycle sustained while result is ready; the pipeline depth from stamp
// accept to result valid is set by the chain of reciprocal multiply and correct steps
// (day split, era, leap days, year of era, minute and hour of day)
// reset clears every stage valid bit and sets the offset to zero; cfg is always ready
// each stage has a valid bit; a stage holds only when it and every stage after it
// are full, so empty stages fill up while result is stalled
module unix_seconds_to_dos_datetime_unit (
    input logic      clk,
    input logic      rst_n,
    udt_cfg_if.sink  cfg,
    udt_in_if.sink   stamp,
    udt_out_if.source result
);
    import udt_pkg::*;

    logic signed [16:0] offset_reg;

    stage_en_t en;
    stage_en_t valid_next;
    stage_en_t valid_reg;

    logic [41:0] secs_next;
    logic [41:0] secs_reg;

    logic [25:0] days;
    logic [16:0] sod;
    logic [6:0]  year7;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] tod;

    logic [31:0] packed_dt;
    logic [31:0] dos_next;
    logic [31:0] dos_reg;

    // a stage may load when it or any stage after it is empty, or the result is taken
    always_comb
    begin
        stage_en_t low_mask;
        for (int k = 0; k < STAGES; k++)
        begin
            low_mask = ~(stage_en_t'('1) << k);
            en[k] = result.ready || !(&(valid_reg | low_mask));
        end
    end

    always_comb
    begin
        valid_next[0] = en[0] ? stamp.valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            offset_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg.valid)
            begin
                offset_reg <= cfg.utc_offset_seconds;
            end
        end
    end

    // local time plus the day bias, always non-negative
    always_comb
    begin
        secs_next = {{2{stamp.unix_seconds[39]}}, stamp.unix_seconds}
                  + {{25{offset_reg[16]}}, offset_reg}
                  + DAY_BIAS_SECS;
    end

    udt_day_split u_day_split (
        .clk  (clk),
        .en   (en),
        .secs (secs_reg),
        .days (days),
        .sod  (sod)
    );

    udt_calendar u_calendar (
        .clk   (clk),
        .en    (en),
        .days  (days),
        .sod   (sod),
        .year7 (year7),
        .month (month),
        .day   (day),
        .tod   (tod)
    );

    always_comb
    begin
        packed_dt = {year7, month, day, tod};
        if (packed_dt > DOS_HIGH)
        begin
            dos_next = DOS_HIGH;
        end
        else if (packed_dt < DOS_LOW)
        begin
            dos_next = DOS_LOW;
        end
        else
        begin
            dos_next = packed_dt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            secs_reg <= secs_next;
        end
        if (en[STAGES-1])
        begin
            dos_reg <= dos_next;
        end
    end

    assign cfg.ready       = 1'b1;
    assign stamp.ready     = en[0];
    assign result.valid    = valid_reg[STAGES-1];
    assign result.dos_word = dos_reg;

endmodule

// File: rtl/core/udt_checker.sv
module udt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        stamp_valid,
    input logic        stamp_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [31:0] dos_word
);
    import udt_pkg::*;

    logic             stamp_take;
    logic             result_take;
    logic [OCC_W-1:0] occ_next;
    logic [OCC_W-1:0] occ_reg;

    assign stamp_take  = stamp_valid && stamp_ready;
    assign result_take = result_valid && result_ready;

    // items inside the block
    always_comb
    begin
        occ_next = occ_reg + OCC_W'(stamp_take) - OCC_W'(result_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    a_take_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> stamp_ready)
        else $error("stamp not ready while result is being taken");

    a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (occ_reg != '0))
        else $error("result valid with no item inside");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(STAGES))
        else $error("more items inside than pipeline stages");

    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (stamp_take && (occ_reg == '0)) |=> !result_valid)
        else $error("result appeared right after an item entered an empty block");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(dos_word)))
        else $error("stalled result dropped or changed");

endmodule

bind unix_seconds_to_dos_datetime_unit udt_checker u_udt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .stamp_valid  (stamp.valid),
    .stamp_ready  (stamp.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .dos_word     (result.dos_word)
);
